@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define RLM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define RLM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rlm_pkg.sv @@
// Shared constants, codes and types of the frame RMS level meter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rlm_pkg;

   // Frame length limits
   localparam int MAX_FRAME = 4096;
   localparam int MIN_FRAME = 16;
   localparam int CNT_W     = $clog2(MAX_FRAME + 1);

   // Configuration registers
   localparam int FRAME_LEN_W    = 13;
   localparam int FRAME_LEN_RST  = 1764;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 13;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_LEN   = 2'd0,
      CSR_STEREO_MODE = 2'd1
   } csr_index_type;

   // Data path widths
   localparam int SAMPLE_W = 16;
   localparam int SQ_W     = 31;
   localparam int ENERGY_W = 43;
   localparam int E_W      = 6;
   localparam int FRAC_W   = 16;
   localparam int LOG_W    = E_W + FRAC_W;
   localparam int MANT_W   = 31;

   // log2 sequencing: binary-search normalize, then one fraction bit per step
   localparam int NORM_STEPS = 6;
   localparam int LOG_STEPS  = NORM_STEPS + FRAC_W;
   localparam int STEP_W     = $clog2(LOG_STEPS);

   // dB conversion: 10*log10(2)*256 in Q16
   localparam int                 K_W     = 26;
   localparam logic [K_W-1:0]     DB_K_Q16 = 26'd50504453;
   localparam int                 MAG_W   = LOG_W;
   localparam int                 PROD_W  = MAG_W + K_W;
   localparam int                 ROUND_SH = 32;

   localparam int LEVEL_W   = 16;
   localparam int LEVEL_MIN = -10000;
   localparam int LEVEL_MAX = 23200;

   // Bars: ceil(level/768) = floor(floor((level+767)/256)/3)
   localparam int BAR_W        = 5;
   localparam int BAR_STEP     = 768;
   localparam int BAR_MAX      = 31;
   localparam int BAR_RECIP    = 171;
   localparam int BAR_RECIP_SH = 9;

   typedef enum logic [4:0] {
      ST_RUN   = 5'b00001,
      ST_FLUSH = 5'b00010,
      ST_LOG   = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [LOG_W-1:0] log_q16;
      logic             zero;
   } lane_result_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic [BAR_W-1:0]          bars;
      logic                      silent;
   } chan_meter_type;

endpackage

@@ sv/rlm_log2.sv @@
// Iterative log2 in Q16 of an unsigned energy word.
// Depends on rlm_pkg; six normalize steps then sixteen squaring steps.
`timescale 1ns / 1ps

module rlm_log2 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rlm_pkg::ENERGY_W-1:0]        x,
   output logic                                busy,
   output logic [rlm_pkg::LOG_W-1:0]           log_q16
);

   logic                            busy_ff, busy_in;
   logic [rlm_pkg::STEP_W-1:0]      step_ff, step_in;
   logic [rlm_pkg::ENERGY_W-1:0]    x_ff, x_in;
   logic [rlm_pkg::E_W-1:0]         e_ff, e_in;
   logic [rlm_pkg::MANT_W-1:0]      m_ff, m_in;
   logic [rlm_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic [rlm_pkg::E_W-1:0]         sh;
   logic [2*rlm_pkg::MANT_W-1:0]    sq;
   logic [rlm_pkg::MANT_W:0]        mq;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      x_in    = x_ff;
      e_in    = e_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      sh      = '0;
      sq      = m_ff * m_ff;
      mq      = sq[2*rlm_pkg::MANT_W-1 -: rlm_pkg::MANT_W+1];
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in    = x;
         e_in    = rlm_pkg::E_W'(rlm_pkg::ENERGY_W - 1);
         frac_in = '0;
      end else if (busy_ff) begin
         if (int'(step_ff) < rlm_pkg::NORM_STEPS) begin
            // shift left by 32,16,..,1 while the top bits are clear
            sh = rlm_pkg::E_W'(1 << (rlm_pkg::NORM_STEPS - 1 - int'(step_ff)));
            if ((x_ff >> (rlm_pkg::ENERGY_W - int'(sh))) == '0) begin
               x_in = x_ff << sh;
               e_in = e_ff - sh;
            end
            m_in = x_in[rlm_pkg::ENERGY_W-1 -: rlm_pkg::MANT_W];
         end else begin
            // square the mantissa; a result of two or more gives a one bit
            if (mq[rlm_pkg::MANT_W]) begin
               m_in    = mq[rlm_pkg::MANT_W:1];
               frac_in = {frac_ff[rlm_pkg::FRAC_W-2:0], 1'b1};
            end else begin
               m_in    = mq[rlm_pkg::MANT_W-1:0];
               frac_in = {frac_ff[rlm_pkg::FRAC_W-2:0], 1'b0};
            end
         end
         step_in = step_ff + 1'b1;
         if (step_ff == rlm_pkg::STEP_W'(rlm_pkg::LOG_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      x_ff    <= x_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
   end

   assign busy    = busy_ff;
   assign log_q16 = {e_ff, frac_ff};

endmodule

@@ sv/rlm_lane.sv @@
// One channel lane: square, saturating energy sum and the log2 of the frame sum.
// Depends on rlm_pkg and rlm_log2.
`timescale 1ns / 1ps

module rlm_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  acc_en,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0]   sample,
   input  logic                                  flush,
   output logic                                  busy,
   output rlm_pkg::lane_result_type              result
);

   logic [rlm_pkg::SQ_W-1:0]        sq_ff, sq_in;
   logic                            sq_vld_ff, sq_vld_in;
   logic [rlm_pkg::ENERGY_W-1:0]    energy_ff, energy_in;
   logic                            zero_ff, zero_in;
   logic [rlm_pkg::ENERGY_W-1:0]    energy_acc;
   logic [rlm_pkg::ENERGY_W:0]      sum;
   logic signed [2*rlm_pkg::SAMPLE_W-1:0] prod;
   logic [rlm_pkg::LOG_W-1:0]       log_q16;

   always_comb begin
      prod      = sample * sample;
      sq_in     = acc_en ? prod[rlm_pkg::SQ_W-1:0] : sq_ff;
      sq_vld_in = acc_en;
      sum = {1'b0, energy_ff} + (rlm_pkg::ENERGY_W+1)'(sq_ff);
      // saturate at all ones
      if (!sq_vld_ff) begin
         energy_acc = energy_ff;
      end else if (sum[rlm_pkg::ENERGY_W]) begin
         energy_acc = '1;
      end else begin
         energy_acc = sum[rlm_pkg::ENERGY_W-1:0];
      end
      energy_in = flush ? '0 : energy_acc;
      zero_in   = flush ? (energy_acc == '0) : zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         energy_ff <= '0;
      end else begin
         sq_vld_ff <= sq_vld_in;
         energy_ff <= energy_in;
      end
      sq_ff   <= sq_in;
      zero_ff <= zero_in;
   end

   rlm_log2 u_log2 (
      .clock   (clock),
      .reset   (reset),
      .start   (flush),
      .x       (energy_acc),
      .busy    (busy),
      .log_q16 (log_q16)
   );

   assign result.log_q16 = log_q16;
   assign result.zero    = zero_ff;

endmodule

@@ sv/rlm_merge.sv @@
// Merge stage: log difference, dB scaling, rounding, clamp and bar count.
// Depends on rlm_pkg; one multiplier per lane, registered before the rounding.
`timescale 1ns / 1ps

module rlm_merge (
   input  logic                              clock,
   input  logic                              load,
   input  rlm_pkg::lane_result_type          lane_left,
   input  rlm_pkg::lane_result_type          lane_right,
   input  logic [rlm_pkg::LOG_W-1:0]         log_n,
   input  logic                              stereo,
   output rlm_pkg::chan_meter_type           meter_left,
   output rlm_pkg::chan_meter_type           meter_right
);

   logic                            neg_l_ff, neg_l_in, neg_r_ff, neg_r_in;
   logic [rlm_pkg::PROD_W-1:0]      prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   logic                            zero_l_ff, zero_l_in, zero_r_ff, zero_r_in;
   logic                            on_r_ff, on_r_in;
   logic signed [rlm_pkg::LOG_W:0]  d_l, d_r;
   logic [rlm_pkg::MAG_W-1:0]       mag_l, mag_r;

   function automatic rlm_pkg::chan_meter_type to_meter(
      input logic                        neg,
      input logic [rlm_pkg::PROD_W-1:0]  prod,
      input logic                        zero,
      input logic                        on);
      rlm_pkg::chan_meter_type            r;
      logic [rlm_pkg::PROD_W-1:0]         rnd;
      logic [rlm_pkg::PROD_W-rlm_pkg::ROUND_SH-1:0] q;
      logic signed [rlm_pkg::LEVEL_W+1:0] lvl;
      logic [rlm_pkg::LEVEL_W-1:0]        up;
      logic [7:0]                         t;
      logic [15:0]                        bq;
      rnd = prod + rlm_pkg::PROD_W'(64'd1 << (rlm_pkg::ROUND_SH - 1));
      q   = rnd[rlm_pkg::PROD_W-1:rlm_pkg::ROUND_SH];
      lvl = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
      if (lvl > (rlm_pkg::LEVEL_W+2)'(rlm_pkg::LEVEL_MAX)) begin
         lvl = (rlm_pkg::LEVEL_W+2)'(rlm_pkg::LEVEL_MAX);
      end else if (lvl < (rlm_pkg::LEVEL_W+2)'(rlm_pkg::LEVEL_MIN)) begin
         lvl = (rlm_pkg::LEVEL_W+2)'(rlm_pkg::LEVEL_MIN);
      end
      up = rlm_pkg::LEVEL_W'(lvl) + rlm_pkg::LEVEL_W'(rlm_pkg::BAR_STEP - 1);
      t  = up[15:8];
      bq = (16'(t) * 16'(rlm_pkg::BAR_RECIP)) >> rlm_pkg::BAR_RECIP_SH;
      r.level  = rlm_pkg::LEVEL_W'(lvl);
      r.silent = 1'b0;
      if (lvl > 0) begin
         r.bars = (bq > 16'(rlm_pkg::BAR_MAX)) ? rlm_pkg::BAR_W'(rlm_pkg::BAR_MAX)
                                               : bq[rlm_pkg::BAR_W-1:0];
      end else begin
         r.bars = '0;
      end
      if (!on) begin
         r = '0;
      end else if (zero) begin
         r        = '0;
         r.silent = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      d_l   = $signed({1'b0, lane_left.log_q16}) - $signed({1'b0, log_n});
      d_r   = $signed({1'b0, lane_right.log_q16}) - $signed({1'b0, log_n});
      mag_l = d_l[rlm_pkg::LOG_W] ? rlm_pkg::MAG_W'(-d_l) : rlm_pkg::MAG_W'(d_l);
      mag_r = d_r[rlm_pkg::LOG_W] ? rlm_pkg::MAG_W'(-d_r) : rlm_pkg::MAG_W'(d_r);
      neg_l_in  = load ? d_l[rlm_pkg::LOG_W] : neg_l_ff;
      neg_r_in  = load ? d_r[rlm_pkg::LOG_W] : neg_r_ff;
      prod_l_in = load ? rlm_pkg::PROD_W'(mag_l) * rlm_pkg::PROD_W'(rlm_pkg::DB_K_Q16)
                       : prod_l_ff;
      prod_r_in = load ? rlm_pkg::PROD_W'(mag_r) * rlm_pkg::PROD_W'(rlm_pkg::DB_K_Q16)
                       : prod_r_ff;
      zero_l_in = load ? lane_left.zero : zero_l_ff;
      zero_r_in = load ? lane_right.zero : zero_r_ff;
      on_r_in   = load ? stereo : on_r_ff;
   end

   always_ff @(posedge clock) begin
      neg_l_ff  <= neg_l_in;
      neg_r_ff  <= neg_r_in;
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
      zero_l_ff <= zero_l_in;
      zero_r_ff <= zero_r_in;
      on_r_ff   <= on_r_in;
   end

   assign meter_left  = to_meter(neg_l_ff, prod_l_ff, zero_l_ff, 1'b1);
   assign meter_right = to_meter(neg_r_ff, prod_r_ff, zero_r_ff, on_r_ff);

endmodule

@@ sv/frame_rms_level_meter.sv @@
// Top level of the frame RMS level meter: channels, frame control, output word.
// Depends on rlm_pkg, rlm_lane, rlm_log2 and rlm_merge.
//
// Usage:
//   req_ channel: one stereo sample word (left, right) per handshake. In mono
//     mode only the left sample is summed.
//   rsp_ channel: one result word per finished frame: level in dB*256, bar
//     count and silent flag per channel; right fields are zero in mono.
//   csr_ channel: index 0 writes frame_len (clamped to 16..4096 when used),
//     index 1 writes stereo_mode. csr_ready is always high; other indexes
//     are dropped. Write only while the block holds no unfinished frame end.
//   Throughput: a sample that does not close a frame takes one cycle. The
//     sample that closes a frame is followed by the frame-end sequence, in
//     which req_ready is low: the flush state, the log2 units (six normalize
//     steps, sixteen squaring steps, then a check that they are idle), the
//     multiply state and the output-load state, which loads the output word.
//   Stall: the output word holds while rsp_ready is low. Samples keep being
//     taken; a later frame end waits in the output-load state until the word
//     has been taken.
//   Reset: sums, sample count and output valid clear; frame_len returns to
//     1764 and stereo_mode to mono.
`timescale 1ns / 1ps

module frame_rms_level_meter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0]   req_left_sample,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0]   req_right_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rlm_pkg::LEVEL_W-1:0]    rsp_level_left_db_x256,
   output logic signed [rlm_pkg::LEVEL_W-1:0]    rsp_level_right_db_x256,
   output logic [rlm_pkg::BAR_W-1:0]             rsp_bars_left,
   output logic [rlm_pkg::BAR_W-1:0]             rsp_bars_right,
   output logic                                  rsp_silent_left,
   output logic                                  rsp_silent_right,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rlm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rlm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   rlm_pkg::state_type               state_ff, state_in;
   logic [rlm_pkg::FRAME_LEN_W-1:0]  frame_len_ff, frame_len_in;
   logic                             stereo_ff, stereo_in;
   logic [rlm_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rlm_pkg::chan_meter_type          out_l_ff, out_l_in, out_r_ff, out_r_in;

   logic [rlm_pkg::CNT_W-1:0]        n;
   logic                             accept, frame_end, flush, load_mul, load_out;
   logic                             busy_l, busy_r, busy_n;
   logic [rlm_pkg::LOG_W-1:0]        log_n;
   rlm_pkg::lane_result_type         res_l, res_r;
   rlm_pkg::chan_meter_type          meter_l, meter_r;

   // Register writes; unknown indexes drop
   always_comb begin
      frame_len_in = frame_len_ff;
      stereo_in    = stereo_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rlm_pkg::CSR_FRAME_LEN:   frame_len_in = csr_wdata[rlm_pkg::FRAME_LEN_W-1:0];
            rlm_pkg::CSR_STEREO_MODE: stereo_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective frame length
   always_comb begin
      if (32'(frame_len_ff) < rlm_pkg::MIN_FRAME) begin
         n = rlm_pkg::CNT_W'(rlm_pkg::MIN_FRAME);
      end else if (32'(frame_len_ff) > rlm_pkg::MAX_FRAME) begin
         n = rlm_pkg::CNT_W'(rlm_pkg::MAX_FRAME);
      end else begin
         n = rlm_pkg::CNT_W'(frame_len_ff);
      end
   end

   // Frame control: take samples in RUN, then walk the frame-end sequence
   always_comb begin
      req_ready = (state_ff == rlm_pkg::ST_RUN);
      accept    = req_valid && req_ready;
      frame_end = accept && (({1'b0, count_ff} + 1'b1) >= {1'b0, n});
      flush     = (state_ff == rlm_pkg::ST_FLUSH);
      load_mul  = (state_ff == rlm_pkg::ST_MUL);
      load_out  = (state_ff == rlm_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);

      count_in = count_ff;
      if (accept) begin
         count_in = frame_end ? '0 : count_ff + 1'b1;
      end

      state_in = state_ff;
      unique case (state_ff)
         rlm_pkg::ST_RUN:   if (frame_end) state_in = rlm_pkg::ST_FLUSH;
         rlm_pkg::ST_FLUSH: state_in = rlm_pkg::ST_LOG;
         rlm_pkg::ST_LOG:   if (!(busy_l || busy_r || busy_n)) state_in = rlm_pkg::ST_MUL;
         rlm_pkg::ST_MUL:   state_in = rlm_pkg::ST_OUT;
         rlm_pkg::ST_OUT:   if (load_out) state_in = rlm_pkg::ST_RUN;
         default:           state_in = rlm_pkg::ST_RUN;
      endcase

      // Output word: load when the slot is free, drop on the handshake
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      out_l_in = load_out ? meter_l : out_l_ff;
      out_r_in = load_out ? meter_r : out_r_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlm_pkg::ST_RUN;
         frame_len_ff <= rlm_pkg::FRAME_LEN_W'(rlm_pkg::FRAME_LEN_RST);
         stereo_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_len_ff <= frame_len_in;
         stereo_ff    <= stereo_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_l_ff <= out_l_in;
      out_r_ff <= out_r_in;
   end

   // Two channel lanes side by side; the right lane sums only in stereo
   rlm_lane u_lane_left (
      .clock  (clock),
      .reset  (reset),
      .acc_en (accept),
      .sample (req_left_sample),
      .flush  (flush),
      .busy   (busy_l),
      .result (res_l)
   );

   rlm_lane u_lane_right (
      .clock  (clock),
      .reset  (reset),
      .acc_en (accept && stereo_ff),
      .sample (req_right_sample),
      .flush  (flush),
      .busy   (busy_r),
      .result (res_r)
   );

   // log2 of the frame length runs alongside the lanes
   rlm_log2 u_log2_n (
      .clock   (clock),
      .reset   (reset),
      .start   (flush),
      .x       (rlm_pkg::ENERGY_W'(n)),
      .busy    (busy_n),
      .log_q16 (log_n)
   );

   rlm_merge u_merge (
      .clock       (clock),
      .load        (load_mul),
      .lane_left   (res_l),
      .lane_right  (res_r),
      .log_n       (log_n),
      .stereo      (stereo_ff),
      .meter_left  (meter_l),
      .meter_right (meter_r)
   );

   assign csr_ready               = 1'b1;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_level_left_db_x256  = out_l_ff.level;
   assign rsp_level_right_db_x256 = out_r_ff.level;
   assign rsp_bars_left           = out_l_ff.bars;
   assign rsp_bars_right          = out_r_ff.bars;
   assign rsp_silent_left         = out_l_ff.silent;
   assign rsp_silent_right        = out_r_ff.silent;

endmodule

@@ sv/rlm_checker.sv @@
// Port-level checker of the frame RMS level meter, bound to the top level.
// Depends on rlm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rlm_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0]   req_left_sample,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0]   req_right_sample,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [rlm_pkg::LEVEL_W-1:0]    rsp_level_left_db_x256,
   input  logic signed [rlm_pkg::LEVEL_W-1:0]    rsp_level_right_db_x256,
   input  logic [rlm_pkg::BAR_W-1:0]             rsp_bars_left,
   input  logic [rlm_pkg::BAR_W-1:0]             rsp_bars_right,
   input  logic                                  rsp_silent_left,
   input  logic                                  rsp_silent_right,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [rlm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rlm_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   // A stalled result word holds its levels and bars
   `RLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_level_left_db_x256) && $stable(rsp_level_right_db_x256) && $stable(rsp_bars_left) && $stable(rsp_bars_right), "result word changed while stalled")

   // Silent channels report zero level and bars
   `RLM_ASSERT_SAME(a_silent_left, clock, reset, rsp_valid && rsp_silent_left, rsp_level_left_db_x256 == 16'sd0 && rsp_bars_left == '0, "silent left with nonzero level")

   `RLM_ASSERT_SAME(a_silent_right, clock, reset, rsp_valid && rsp_silent_right, rsp_level_right_db_x256 == 16'sd0 && rsp_bars_right == '0, "silent right with nonzero level")

   // Left bars follow the sign of the left level
   `RLM_ASSERT_SAME(a_bars_left, clock, reset, rsp_valid, (rsp_level_left_db_x256 > 16'sd0) == (rsp_bars_left != '0), "left bars disagree with level")

   // Left level stays inside the clamp range
   `RLM_ASSERT_SAME(a_level_range, clock, reset, rsp_valid, rsp_level_left_db_x256 >= -16'sd10000 && rsp_level_left_db_x256 <= 16'sd23200, "left level outside clamp range")

endmodule

bind frame_rms_level_meter rlm_checker u_rlm_checker (.*);

@@ verif/tb_frame_rms_level_meter.sv @@
// Self-checking testbench for the frame RMS level meter: sample words in, one
// level word per finished frame out. Depends on rlm_pkg and frame_rms_level_meter.
`timescale 1ns / 1ps

module tb_frame_rms_level_meter;

   localparam int CLK_HALF        = 6;
   localparam int LIMIT_CYCLES    = 500000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int RANDOM_ITEMS    = 400;

   // Arithmetic of the level computation
   localparam int          FRAME_FLOOR = 16;
   localparam int          FRAME_CEIL  = 4096;
   localparam logic [63:0] ENERGY_CAP  = 64'h7FF_FFFF_FFFF;
   localparam logic [63:0] DB_SCALE    = 64'd50504453;
   localparam longint      LVL_FLOOR   = -10000;
   localparam longint      LVL_CEIL    = 23200;
   localparam longint      BAR_SIZE    = 768;
   localparam longint      BAR_TOP     = 31;

   // Register indexes that the block has no register for
   localparam logic [rlm_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [rlm_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] right;
   } sample_pair_type;

   typedef struct packed {
      logic signed [15:0] level;
      logic [4:0]         bars;
      logic               silent;
   } channel_reading_type;

   typedef struct packed {
      channel_reading_type left;
      channel_reading_type right;
   } meter_word_type;

   typedef enum int {
      WAVE_FULL, WAVE_QUIET, WAVE_SPARSE, WAVE_SILENT, WAVE_PEAK, WAVE_MIXED
   } wave_kind_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic signed [rlm_pkg::SAMPLE_W-1:0] req_left_sample = '0;
   logic signed [rlm_pkg::SAMPLE_W-1:0] req_right_sample = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [rlm_pkg::LEVEL_W-1:0]  rsp_level_left_db_x256;
   logic signed [rlm_pkg::LEVEL_W-1:0]  rsp_level_right_db_x256;
   logic [rlm_pkg::BAR_W-1:0]           rsp_bars_left;
   logic [rlm_pkg::BAR_W-1:0]           rsp_bars_right;
   logic                                rsp_silent_left;
   logic                                rsp_silent_right;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [rlm_pkg::CSR_IDX_W-1:0]       csr_index = rlm_pkg::CSR_FRAME_LEN;
   logic [rlm_pkg::CSR_DATA_W-1:0]      csr_wdata = '0;

   frame_rms_level_meter i_dut (.*);

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // Mirror of the block: register copies, running sums and sample count.
   logic [12:0]  cfg_frame_len;
   logic         cfg_stereo;
   logic [63:0]  energy_left_acc;
   logic [63:0]  energy_right_acc;
   int unsigned  frame_fill;

   sample_pair_type sample_backlog[$];    // words waiting for the driver
   meter_word_type  readings_due[$];      // level words owed by the block
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_stall_pct = 0;
   logic         rsp_hold_on = 1'b0;
   logic         req_fired = 1'b0;
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   event         rsp_hold_kick;

   // log2 in Q16: integer part from the top set bit, then sixteen
   // squarings of a Q30 mantissa, each yielding one fraction bit.
   function automatic longint log2_fixed(input logic [63:0] x);
      int          msb;
      logic [63:0] mant;
      logic [15:0] frac;
      msb = 63;
      while (msb > 0 && !x[msb]) msb--;
      if (msb >= 30) mant = x >> (msb - 30);
      else mant = x << (30 - msb);
      frac = '0;
      for (int i = 0; i < 16; i++) begin
         mant = (mant * mant) >> 30;
         frac = frac << 1;
         if (mant >= (64'd1 << 31)) begin
            mant = mant >> 1;
            frac[0] = 1'b1;
         end
      end
      return (longint'(msb) << 16) | longint'(frac);
   endfunction

   // Level, bar count and silent flag of one channel at frame end.
   function automatic channel_reading_type channel_meter(input logic [63:0] energy,
                                                         input int unsigned frame_n);
      channel_reading_type rd;
      longint           diff;
      logic [63:0]      mag;
      logic [63:0]      rounded;
      longint           lvl;
      longint           bars;
      rd = '0;
      if (energy == 0) begin
         rd.silent = 1'b1;
         return rd;
      end
      diff = log2_fixed(energy) - log2_fixed(64'(frame_n));
      mag = 64'(diff < 0 ? -diff : diff) * DB_SCALE;
      // round half away from zero: round the magnitude, then restore the sign
      rounded = (mag + (64'd1 << 31)) >> 32;
      lvl = (diff < 0) ? -longint'(rounded) : longint'(rounded);
      if (lvl < LVL_FLOOR) lvl = LVL_FLOOR;
      if (lvl > LVL_CEIL) lvl = LVL_CEIL;
      bars = 0;
      if (lvl > 0) begin
         bars = (lvl + BAR_SIZE - 1) / BAR_SIZE;
         if (bars > BAR_TOP) bars = BAR_TOP;
      end
      rd.level = lvl[15:0];
      rd.bars  = bars[4:0];
      return rd;
   endfunction

   function automatic logic [63:0] add_square(input logic [63:0] acc,
                                              input logic signed [15:0] smp);
      longint      sv;
      logic [63:0] sum;
      sv = smp;
      sum = acc + 64'(sv * sv);
      return (sum > ENERGY_CAP) ? ENERGY_CAP : sum;
   endfunction

   // Advance the mirror by one accepted sample word; owe a level word
   // when the frame closes. The mode at the closing sample decides the word.
   function automatic void meter_accumulate(input sample_pair_type smp);
      int unsigned    frame_n;
      meter_word_type word;
      frame_n = cfg_frame_len;
      if (frame_n < FRAME_FLOOR) frame_n = FRAME_FLOOR;
      if (frame_n > FRAME_CEIL) frame_n = FRAME_CEIL;
      energy_left_acc = add_square(energy_left_acc, smp.left);
      if (cfg_stereo) energy_right_acc = add_square(energy_right_acc, smp.right);
      frame_fill++;
      if (frame_fill >= frame_n) begin
         word = '0;
         word.left = channel_meter(energy_left_acc, frame_n);
         if (cfg_stereo) word.right = channel_meter(energy_right_acc, frame_n);
         readings_due.push_back(word);
         energy_left_acc  = '0;
         energy_right_acc = '0;
         frame_fill       = 0;
      end
   endfunction

   function automatic void compare_field(input string name,
                                         input logic signed [16:0] want,
                                         input logic signed [16:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [15:0] wave_sample(input wave_kind_type kind);
      wave_kind_type k;
      int unsigned   bits;
      logic [15:0]   mag;
      k = kind;
      if (k == WAVE_MIXED) k = wave_kind_type'($urandom_range(0, 4));
      case (k)
         WAVE_QUIET: begin
            bits = $urandom_range(0, 8);
            mag = 16'($urandom_range(0, (1 << bits) - 1));
            return $urandom_range(0, 1) ? -mag : mag;
         end
         WAVE_SPARSE: begin
            if ($urandom_range(0, 15) != 0) return 16'h0000;
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0001;
         end
         WAVE_SILENT: return 16'h0000;
         WAVE_PEAK:   return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         default:     return 16'($urandom);
      endcase
   endfunction

   function automatic wave_kind_type any_wave();
      return wave_kind_type'($urandom_range(0, 5));
   endfunction

   function automatic void queue_samples(input int unsigned count,
                                         input wave_kind_type kind_left,
                                         input wave_kind_type kind_right);
      for (int unsigned i = 0; i < count; i++)
         sample_backlog.push_back(sample_pair_type'{wave_sample(kind_left),
                                                    wave_sample(kind_right)});
   endfunction

   // Monitor: take register writes, sample words and result words at the
   // rising edge, in that order.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin : watch
      meter_word_type want;
      req_fired <= !reset && req_valid && req_ready;
      if (reset) begin
         cfg_frame_len    = 13'(rlm_pkg::FRAME_LEN_RST);
         cfg_stereo       = 1'b0;
         energy_left_acc  = '0;
         energy_right_acc = '0;
         frame_fill       = 0;
         readings_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               rlm_pkg::CSR_FRAME_LEN:   cfg_frame_len = csr_wdata;
               rlm_pkg::CSR_STEREO_MODE: cfg_stereo = csr_wdata[0];
               default: ;   // drop writes to unused indexes
            endcase
         end
         if (req_valid && req_ready)
            meter_accumulate(sample_pair_type'{req_left_sample, req_right_sample});
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               $error("result word with no frame end pending");
               mismatch_count++;
            end else begin
               want = readings_due.pop_front();
               compare_field("level_left_db_x256", want.left.level,
                             rsp_level_left_db_x256);
               compare_field("level_right_db_x256", want.right.level,
                             rsp_level_right_db_x256);
               compare_field("bars_left", want.left.bars, rsp_bars_left);
               compare_field("bars_right", want.right.bars, rsp_bars_right);
               compare_field("silent_left", want.left.silent, rsp_silent_left);
               compare_field("silent_right", want.right.silent, rsp_silent_right);
            end
         end
      end
   end

   // Driver: offer the next backlog word at the falling edge; hold the
   // current one until it is taken.
   always @(negedge clock) begin : drive_req
      sample_pair_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = sample_backlog.pop_front();
            req_valid        <= 1'b1;
            req_left_sample  <= nxt.left;
            req_right_sample <= nxt.right;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, or a solid hold-off while the long hold runs.
   always @(negedge clock) begin
      if (reset || rsp_hold_on) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Long hold-off, counted here so the sender keeps pushing words meanwhile.
   always begin
      @(rsp_hold_kick);
      rsp_hold_on = 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold_on = 1'b0;
   end

   task automatic csr_write(input logic [rlm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rlm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every word is sent and every level word is back, then let
   // the block settle before anything touches its registers.
   task automatic wait_quiet();
      while (sample_backlog.size() != 0 || req_valid || readings_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void set_idling(input int unsigned send_pct,
                                      input int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endfunction

   initial begin : stimulus
      int unsigned random_items;
      int unsigned phase_no;
      int unsigned pick;
      int unsigned frames;
      int unsigned tail;
      int unsigned frame_n;
      logic [12:0] len_word;
      logic [12:0] mode_word;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: mono, 1764-sample frame. Open with the sample
      // extremes; the right word carries full-scale noise that must not count.
      set_idling(0, 0);
      sample_backlog.push_back(sample_pair_type'{16'sh8000, 16'sh7FFF});
      sample_backlog.push_back(sample_pair_type'{16'sh7FFF, 16'sh8000});
      sample_backlog.push_back(sample_pair_type'{16'sh0000, 16'shFFFF});
      sample_backlog.push_back(sample_pair_type'{16'shFFFF, 16'sh0001});
      sample_backlog.push_back(sample_pair_type'{16'sh0001, 16'sh5A5A});
      queue_samples(rlm_pkg::FRAME_LEN_RST - 5, WAVE_MIXED, WAVE_FULL);
      wait_quiet();

      // Frame length below the floor (clamps to 16), stereo: full-scale
      // left against a silent right.
      csr_write(rlm_pkg::CSR_FRAME_LEN, 13'd0);
      csr_write(rlm_pkg::CSR_STEREO_MODE, 13'd1);
      for (int i = 0; i < 16; i++)
         sample_backlog.push_back(sample_pair_type'{(i % 2) ? 16'sh7FFF : 16'sh8000,
                                                    16'sh0000});
      wait_quiet();

      // Back to mono and leave a frame part-filled with unit samples; the
      // next phase rewrites the registers mid-frame.
      csr_write(rlm_pkg::CSR_STEREO_MODE, 13'd0);
      for (int i = 0; i < 9; i++)
         sample_backlog.push_back(sample_pair_type'{(i % 2) ? 16'sh0001 : 16'shFFFF,
                                                    16'sh7FFF});
      wait_quiet();

      // Back-pressure: hold the result side for a long stretch while short
      // stereo frames keep coming, so the block stalls its sample input.
      csr_write(rlm_pkg::CSR_FRAME_LEN, 13'd16);
      csr_write(rlm_pkg::CSR_STEREO_MODE, 13'h1FFF);
      -> rsp_hold_kick;
      for (int i = 0; i < 12; i++) queue_samples(16, any_wave(), any_wave());
      wait_quiet();

      // Unused register indexes leave the short stereo frame in force; one
      // more frame at full scale on the left shows it.
      csr_write(CSR_SPARE_A, 13'($urandom));
      csr_write(CSR_SPARE_B, 13'h1FFF);
      queue_samples(16, WAVE_PEAK, WAVE_QUIET);
      wait_quiet();

      // Random phases: new settings while idle, then a few frames and a
      // part-filled tail that runs into the next settings.
      random_items = 0;
      phase_no = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase_no % 4)
            0: set_idling(0, 0);
            1: set_idling(84, 0);
            2: set_idling(0, 84);
            default: set_idling(9, 9);
         endcase
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) len_word = 13'($urandom_range(16, 40));
            else if (pick < 17) len_word = 13'($urandom_range(0, 15));
            else if (pick < 19) len_word = 13'($urandom_range(41, 200));
            else len_word = 13'($urandom_range(201, 300));
            csr_write(rlm_pkg::CSR_FRAME_LEN, len_word);
         end
         if ($urandom_range(0, 2) != 0) begin
            mode_word = 13'($urandom);
            csr_write(rlm_pkg::CSR_STEREO_MODE, mode_word);
         end
         frame_n = cfg_frame_len;
         if (frame_n < FRAME_FLOOR) frame_n = FRAME_FLOOR;
         if (frame_n > FRAME_CEIL) frame_n = FRAME_CEIL;
         frames = (frame_n > 64) ? 1 : $urandom_range(1, 4);
         tail = $urandom_range(0, frame_n - 1);
         for (int unsigned f = 0; f < frames; f++)
            queue_samples(frame_n, any_wave(), any_wave());
         queue_samples(tail, any_wave(), any_wave());
         random_items += frames * frame_n + tail;
         phase_no++;
         wait_quiet();
      end

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
